FILE: hdl/spdr_pkg.sv
// Shared types and constants of the SPI DAC refresh sequencer.
package spdr_pkg;

   localparam int MODE_W       = 2;
   localparam int ADDR_W       = 4;
   localparam int DATA_W       = 10;
   localparam int WORD_W       = 16;
   localparam int MAP_W        = 40;
   localparam int MAP_CHANNELS = MAP_W / ADDR_W;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 64;

   localparam logic [MAP_W-1:0] MAP_RESET = 40'hA987654321;

   // Input item modes
   localparam logic [MODE_W-1:0] MODE_SET  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GET  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RX   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TICK = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_MAP     = 2'd0;
   localparam logic [1:0] REG_REVERSE = 2'd1;
   localparam logic [1:0] REG_LD_MODE = 2'd2;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_WRITE,
      SEQ_WAIT,
      SEQ_LD_START,
      SEQ_LD_END,
      SEQ_DONE
   } seq_state_type;

   typedef enum logic [2:0] {
      C_IDLE,
      C_EXEC,
      C_SEARCH,
      C_BUILD,
      C_DECODE,
      C_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic [MAP_W-1:0] map;
      logic             reverse;
      logic             ld_first_only;
   } cfg_type;

   typedef struct packed {
      logic take;
      logic recv;
      logic send;
      logic hit;
      logic build;
      logic decode;
      logic advance;
      logic clear_counts;
      logic load_result;
      logic ld_active;
      logic busy;
   } cmd_type;

   typedef struct packed {
      logic              in_valid;
      logic [MODE_W-1:0] mode;
      logic              match;
      logic              last;
      logic              send_left;
      logic              counts_equal;
      logic              sent_odd;
      logic              all_done;
      logic              out_free;
   } stat_type;

endpackage

FILE: hdl/spdr_if.sv
// Request and response channel interfaces of the SPI DAC refresh sequencer.
interface spdr_req_if;
   logic                           valid;
   logic                           ready;
   logic [spdr_pkg::MODE_W-1:0]    mode;
   logic [spdr_pkg::ADDR_W-1:0]    channel_address;
   logic [spdr_pkg::DATA_W-1:0]    channel_value;
   logic [spdr_pkg::WORD_W-1:0]    rx_word;

   modport source (output valid, mode, channel_address, channel_value, rx_word,
                   input ready);
   modport sink (input valid, mode, channel_address, channel_value, rx_word,
                 output ready);
endinterface

interface spdr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           tx_valid;
   logic [spdr_pkg::WORD_W-1:0]    tx_word;
   logic                           ld_active;
   logic                           lookup_found;
   logic                           readback_valid;
   logic [spdr_pkg::DATA_W-1:0]    readback_value;
   logic                           busy_res;

   modport source (output valid, tx_valid, tx_word, ld_active, lookup_found,
                   readback_valid, readback_value, busy_res, input ready);
   modport sink (input valid, tx_valid, tx_word, ld_active, lookup_found,
                 readback_valid, readback_value, busy_res, output ready);
endinterface

FILE: hdl/spi_dac_refresh_sequencer_top.sv
// SPI DAC refresh sequencer: one request word in, one response word out.
// A received SPI word and most ticks go through the execute and result states to the
// response register; set/get add a channel search that ends at the first match or the
// last channel; the refresh snapshot tick and the readback decode tick walk all CHANNELS, one channel per cycle.
// One word at a time: a new request is taken only after the last response is loaded into the output register.
// Reset (synchronous, active high) clears the sequence, counters, values and flags.
module spi_dac_refresh_sequencer_top #(
   parameter int CHANNELS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   spdr_req_if.sink                            req_ch,
   spdr_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [spdr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [spdr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [spdr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   spdr_pkg::cfg_type  cfg;
   spdr_pkg::cmd_type  cmd;
   spdr_pkg::stat_type stat;

   spdr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   spdr_dpath #(
      .CHANNELS (CHANNELS)
   ) u_dpath (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .cmd   (cmd),
      .stat  (stat),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   spdr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .stat  (stat),
      .cmd   (cmd)
   );

endmodule

FILE: hdl/spdr_csr.sv
// APB configuration registers of the SPI DAC refresh sequencer.
module spdr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [spdr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [spdr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [spdr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output spdr_pkg::cfg_type                   cfg
);

   spdr_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]        reg_index;
   logic              wr_en;

   assign reg_index  = csr_paddr[4:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            spdr_pkg::REG_MAP:     cfg_in.map = csr_pwdata[spdr_pkg::MAP_W-1:0];
            spdr_pkg::REG_REVERSE: cfg_in.reverse = csr_pwdata[0];
            spdr_pkg::REG_LD_MODE: cfg_in.ld_first_only = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map           <= spdr_pkg::MAP_RESET;
         cfg_ff.reverse       <= 1'b0;
         cfg_ff.ld_first_only <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         spdr_pkg::REG_MAP:     csr_prdata = spdr_pkg::CSR_DATA_W'(cfg_ff.map);
         spdr_pkg::REG_REVERSE: csr_prdata = spdr_pkg::CSR_DATA_W'(cfg_ff.reverse);
         spdr_pkg::REG_LD_MODE: csr_prdata = spdr_pkg::CSR_DATA_W'(cfg_ff.ld_first_only);
         default:               csr_prdata = '0;
      endcase
   end

endmodule

FILE: hdl/spdr_dpath.sv
// Datapath: channel storage, frame snapshot, counters, walk index and result word.
module spdr_dpath #(
   parameter int CHANNELS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spdr_pkg::cfg_type    cfg,
   input  spdr_pkg::cmd_type    cmd,
   output spdr_pkg::stat_type   stat,
   spdr_req_if.sink             req,
   spdr_rsp_if.source           rsp
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(2 * CHANNELS + 1);
   localparam int RB_W  = spdr_pkg::WORD_W - 2;
   localparam logic [CNT_W-1:0] PAIR_TOTAL = CNT_W'(2 * CHANNELS);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(CHANNELS - 1);

   function automatic logic [spdr_pkg::DATA_W-1:0] mirror(
      input logic [spdr_pkg::DATA_W-1:0] v);
      logic [spdr_pkg::DATA_W-1:0] r;
      for (int k = 0; k < spdr_pkg::DATA_W; k++) begin
         r[k] = v[spdr_pkg::DATA_W-1-k];
      end
      return r;
   endfunction

   // latched word
   logic [spdr_pkg::MODE_W-1:0] mode_ff;
   logic [spdr_pkg::ADDR_W-1:0] addr_ff;
   logic [spdr_pkg::DATA_W-1:0] value_ff;
   logic [spdr_pkg::WORD_W-1:0] rx_ff;

   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] sent_ff, recv_ff, recv_next;

   logic [spdr_pkg::DATA_W-1:0] req_vals_ff [CHANNELS];
   logic [spdr_pkg::WORD_W-1:0] frames_ff   [CHANNELS];
   logic [RB_W-1:0]             rb_words_ff [CHANNELS];
   logic [spdr_pkg::DATA_W-1:0] rb_vals_ff  [CHANNELS];
   logic [CHANNELS-1:0]         verified_ff;

   // result being built
   logic                        res_tx_valid_ff;
   logic [spdr_pkg::WORD_W-1:0] res_tx_word_ff;
   logic                        res_found_ff;
   logic                        res_rb_valid_ff;
   logic [spdr_pkg::DATA_W-1:0] res_rb_value_ff;

   // output register
   logic                        out_valid_ff;
   logic                        out_tx_valid_ff;
   logic [spdr_pkg::WORD_W-1:0] out_tx_word_ff;
   logic                        out_ld_ff;
   logic                        out_found_ff;
   logic                        out_rb_valid_ff;
   logic [spdr_pkg::DATA_W-1:0] out_rb_value_ff;
   logic                        out_busy_ff;

   logic                        accept;
   logic                        recv_ok;
   logic [5:0]                  map_base;
   logic [spdr_pkg::ADDR_W-1:0] addr_at_idx;
   logic [spdr_pkg::DATA_W-1:0] build_data;
   logic [RB_W-1:0]             rb_shifted;
   logic [spdr_pkg::DATA_W-1:0] decode_data;
   logic [IDX_W-1:0]            send_idx;
   logic [IDX_W-1:0]            store_idx;

   assign accept    = req.valid & cmd.take;
   assign req.ready = cmd.take;

   // channel address from the map; channels past the map read address zero
   assign map_base    = 6'({idx_ff, 2'b00});
   assign addr_at_idx = (int'(idx_ff) < spdr_pkg::MAP_CHANNELS) ?
                        cfg.map[map_base +: spdr_pkg::ADDR_W] : '0;

   assign build_data  = cfg.reverse ? mirror(req_vals_ff[idx_ff]) : req_vals_ff[idx_ff];
   assign rb_shifted  = rb_words_ff[idx_ff];
   assign decode_data = cfg.reverse ? mirror(rb_shifted[spdr_pkg::DATA_W-1:0]) :
                        rb_shifted[spdr_pkg::DATA_W-1:0];

   assign recv_ok   = cmd.recv & (recv_ff < sent_ff);
   assign recv_next = recv_ff + 1'b1;
   assign send_idx  = IDX_W'(sent_ff >> 1);
   assign store_idx = IDX_W'((recv_next >> 1) - 1'b1);

   assign stat.in_valid     = req.valid;
   assign stat.mode         = mode_ff;
   assign stat.match        = (addr_at_idx == addr_ff);
   assign stat.last         = (idx_ff == LAST_IDX);
   assign stat.send_left    = (sent_ff < PAIR_TOTAL);
   assign stat.counts_equal = (recv_ff == sent_ff);
   assign stat.sent_odd     = sent_ff[0];
   assign stat.all_done     = (sent_ff >= PAIR_TOTAL) & (recv_ff >= PAIR_TOTAL);
   assign stat.out_free     = ~out_valid_ff | rsp.ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req.mode;
         addr_ff  <= req.channel_address;
         value_ff <= req.channel_value;
         rx_ff    <= req.rx_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (accept) begin
         idx_ff <= '0;
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= '0;
         recv_ff <= '0;
      end else if (cmd.clear_counts) begin
         sent_ff <= '0;
         recv_ff <= '0;
      end else begin
         if (cmd.send) begin
            sent_ff <= sent_ff + 1'b1;
         end
         if (recv_ok) begin
            recv_ff <= recv_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            req_vals_ff[i] <= '0;
         end
         verified_ff <= '0;
      end else begin
         if (cmd.hit && mode_ff == spdr_pkg::MODE_SET) begin
            req_vals_ff[idx_ff] <= value_ff;
            verified_ff[idx_ff] <= 1'b0;
         end
         if (cmd.decode && rb_shifted[RB_W-1 -: spdr_pkg::ADDR_W] == addr_at_idx) begin
            verified_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build) begin
         frames_ff[idx_ff] <= {2'b00, addr_at_idx, build_data};
      end
      if (recv_ok && !recv_next[0]) begin
         rb_words_ff[store_idx] <= rx_ff[spdr_pkg::WORD_W-1:2];
      end
      if (cmd.decode) begin
         rb_vals_ff[idx_ff] <= decode_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_tx_valid_ff <= 1'b0;
         res_found_ff    <= 1'b0;
         res_rb_valid_ff <= 1'b0;
         res_tx_word_ff  <= '0;
         res_rb_value_ff <= '0;
      end else if (accept) begin
         res_tx_valid_ff <= 1'b0;
         res_found_ff    <= 1'b0;
         res_rb_valid_ff <= 1'b0;
         res_tx_word_ff  <= '0;
         res_rb_value_ff <= '0;
      end else begin
         if (cmd.send) begin
            res_tx_valid_ff <= 1'b1;
            res_tx_word_ff  <= frames_ff[send_idx];
         end
         if (cmd.hit) begin
            res_found_ff <= 1'b1;
            if (mode_ff == spdr_pkg::MODE_GET && verified_ff[idx_ff]) begin
               res_rb_valid_ff <= 1'b1;
               res_rb_value_ff <= rb_vals_ff[idx_ff];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         out_tx_valid_ff <= res_tx_valid_ff;
         out_tx_word_ff  <= res_tx_word_ff;
         out_ld_ff       <= cmd.ld_active;
         out_found_ff    <= res_found_ff;
         out_rb_valid_ff <= res_rb_valid_ff;
         out_rb_value_ff <= res_rb_value_ff;
         out_busy_ff     <= cmd.busy;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.tx_valid       = out_tx_valid_ff;
   assign rsp.tx_word        = out_tx_word_ff;
   assign rsp.ld_active      = out_ld_ff;
   assign rsp.lookup_found   = out_found_ff;
   assign rsp.readback_valid = out_rb_valid_ff;
   assign rsp.readback_value = out_rb_value_ff;
   assign rsp.busy_res       = out_busy_ff;

endmodule

FILE: hdl/spdr_ctrl.sv
// Controller: word sequencing and the refresh sequence state machine.
module spdr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  spdr_pkg::cfg_type    cfg,
   input  spdr_pkg::stat_type   stat,
   output spdr_pkg::cmd_type    cmd
);

   spdr_pkg::ctrl_state_type state_ff, state_in;
   spdr_pkg::seq_state_type  seq_ff, seq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spdr_pkg::C_IDLE;
         seq_ff   <= spdr_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      seq_in   = seq_ff;
      cmd      = '0;
      case (state_ff)
         spdr_pkg::C_IDLE: begin
            cmd.take = 1'b1;
            if (stat.in_valid) begin
               state_in = spdr_pkg::C_EXEC;
            end
         end
         spdr_pkg::C_EXEC: begin
            state_in = spdr_pkg::C_RESULT;
            case (stat.mode)
               spdr_pkg::MODE_SET, spdr_pkg::MODE_GET: state_in = spdr_pkg::C_SEARCH;
               spdr_pkg::MODE_RX: cmd.recv = (seq_ff == spdr_pkg::SEQ_WAIT);
               default: begin
                  case (seq_ff)
                     spdr_pkg::SEQ_WRITE: begin
                        if (stat.send_left) begin
                           cmd.send = 1'b1;
                           seq_in   = spdr_pkg::SEQ_WAIT;
                        end else begin
                           seq_in = spdr_pkg::SEQ_DONE;
                        end
                     end
                     spdr_pkg::SEQ_WAIT: begin
                        if (stat.counts_equal) begin
                           if (!cfg.ld_first_only || stat.sent_odd) begin
                              seq_in = spdr_pkg::SEQ_LD_START;
                           end else begin
                              seq_in = stat.all_done ? spdr_pkg::SEQ_DONE :
                                                       spdr_pkg::SEQ_WRITE;
                           end
                        end
                     end
                     spdr_pkg::SEQ_LD_START: seq_in = spdr_pkg::SEQ_LD_END;
                     spdr_pkg::SEQ_LD_END: begin
                        seq_in = stat.all_done ? spdr_pkg::SEQ_DONE : spdr_pkg::SEQ_WRITE;
                     end
                     spdr_pkg::SEQ_DONE: state_in = spdr_pkg::C_DECODE;
                     default: state_in = spdr_pkg::C_BUILD;
                  endcase
               end
            endcase
         end
         spdr_pkg::C_SEARCH: begin
            // first matching channel wins
            if (stat.match) begin
               cmd.hit  = 1'b1;
               state_in = spdr_pkg::C_RESULT;
            end else if (stat.last) begin
               state_in = spdr_pkg::C_RESULT;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         spdr_pkg::C_BUILD: begin
            cmd.build = 1'b1;
            if (stat.last) begin
               cmd.clear_counts = 1'b1;
               seq_in           = spdr_pkg::SEQ_WRITE;
               state_in         = spdr_pkg::C_RESULT;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         spdr_pkg::C_DECODE: begin
            cmd.decode = 1'b1;
            if (stat.last) begin
               seq_in   = spdr_pkg::SEQ_IDLE;
               state_in = spdr_pkg::C_RESULT;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         spdr_pkg::C_RESULT: begin
            cmd.ld_active = (seq_ff == spdr_pkg::SEQ_LD_END);
            cmd.busy      = (seq_ff != spdr_pkg::SEQ_IDLE);
            // hold until the output register can take the word
            if (stat.out_free) begin
               cmd.load_result = 1'b1;
               state_in        = spdr_pkg::C_IDLE;
            end
         end
         default: state_in = spdr_pkg::C_IDLE;
      endcase
   end

endmodule

FILE: tb/tb_spi_dac_refresh_sequencer_top.sv
// Self-checking testbench of the SPI DAC refresh sequencer: stimulus, prediction, compare.
`timescale 1ns / 1ps

module tb_spi_dac_refresh_sequencer_top;

   localparam int NUM_CHANNELS   = 10;
   localparam int PHASE_ITEMS    = 90;
   localparam int NUM_PHASES     = 5;
   localparam int SETTLE_CYCLES  = NUM_CHANNELS + 6;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int FIELD_W        = spdr_pkg::WORD_W;
   localparam logic [4:0] PAIR_TOTAL = 5'(2 * NUM_CHANNELS);

   typedef struct packed {
      logic [spdr_pkg::MODE_W-1:0] mode;
      logic [spdr_pkg::ADDR_W-1:0] addr;
      logic [spdr_pkg::DATA_W-1:0] value;
      logic [spdr_pkg::WORD_W-1:0] rx;
   } dac_req_type;

   typedef struct packed {
      logic                        tx_valid;
      logic [spdr_pkg::WORD_W-1:0] tx_word;
      logic                        ld_active;
      logic                        lookup_found;
      logic                        readback_valid;
      logic [spdr_pkg::DATA_W-1:0] readback_value;
      logic                        busy;
   } dac_rsp_type;

   logic clock;
   logic reset;

   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [spdr_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [spdr_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [spdr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   spdr_req_if req_ch ();
   spdr_rsp_if rsp_ch ();

   spi_dac_refresh_sequencer_top #(
      .CHANNELS(NUM_CHANNELS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Predicted block state and configuration
   logic [spdr_pkg::MAP_W-1:0]  map_cfg;
   logic                        reverse_cfg;
   logic                        ld_first_cfg;
   spdr_pkg::seq_state_type     seq_now;
   logic [4:0]                  sent_total;
   logic [4:0]                  recv_total;
   logic [spdr_pkg::DATA_W-1:0] wanted_value [NUM_CHANNELS];
   logic                        verified_flag [NUM_CHANNELS];
   logic [spdr_pkg::WORD_W-1:0] readback_raw [NUM_CHANNELS];
   logic [spdr_pkg::DATA_W-1:0] readback_decoded [NUM_CHANNELS];
   logic [spdr_pkg::WORD_W-1:0] tx_frame [NUM_CHANNELS];

   dac_req_type queued_requests [$];
   dac_rsp_type awaited_responses [$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   int stall_cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [spdr_pkg::ADDR_W-1:0] channel_addr(int ch);
      return map_cfg[spdr_pkg::ADDR_W*ch +: spdr_pkg::ADDR_W];
   endfunction

   function automatic logic [spdr_pkg::DATA_W-1:0] mirror_bits(
      logic [spdr_pkg::DATA_W-1:0] v);
      logic [spdr_pkg::DATA_W-1:0] r;
      for (int k = 0; k < spdr_pkg::DATA_W; k++) r[k] = v[spdr_pkg::DATA_W-1-k];
      return r;
   endfunction

   // First channel whose address matches, -1 when none
   function automatic int lookup_channel(logic [spdr_pkg::ADDR_W-1:0] a);
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (channel_addr(i) == a) return i;
      end
      return -1;
   endfunction

   function automatic dac_rsp_type predict_refresh_response(dac_req_type w);
      dac_rsp_type                 r;
      int                          idx;
      logic                        all_done;
      logic [13:0]                 d;
      logic [spdr_pkg::DATA_W-1:0] dv;
      r = '0;
      all_done = (sent_total >= PAIR_TOTAL) && (recv_total >= PAIR_TOTAL);
      case (w.mode)
         spdr_pkg::MODE_SET: begin
            idx = lookup_channel(w.addr);
            if (idx >= 0) begin
               r.lookup_found = 1'b1;
               verified_flag[idx] = 1'b0;
               wanted_value[idx] = w.value;
            end
         end
         spdr_pkg::MODE_GET: begin
            idx = lookup_channel(w.addr);
            if (idx >= 0) begin
               r.lookup_found = 1'b1;
               if (verified_flag[idx]) begin
                  r.readback_valid = 1'b1;
                  r.readback_value = readback_decoded[idx];
               end
            end
         end
         spdr_pkg::MODE_RX: begin
            if (seq_now == spdr_pkg::SEQ_WAIT && recv_total < sent_total) begin
               recv_total = recv_total + 5'd1;
               // keep only the second word of each pair
               if (!recv_total[0]) readback_raw[int'(recv_total >> 1) - 1] = w.rx;
            end
         end
         default: begin
            case (seq_now)
               spdr_pkg::SEQ_WRITE: begin
                  if (sent_total < PAIR_TOTAL) begin
                     r.tx_valid = 1'b1;
                     r.tx_word = tx_frame[int'(sent_total >> 1)];
                     sent_total = sent_total + 5'd1;
                     seq_now = spdr_pkg::SEQ_WAIT;
                  end else begin
                     seq_now = spdr_pkg::SEQ_DONE;
                  end
               end
               spdr_pkg::SEQ_WAIT: begin
                  if (recv_total == sent_total) begin
                     if (!ld_first_cfg || sent_total[0]) seq_now = spdr_pkg::SEQ_LD_START;
                     else seq_now = all_done ? spdr_pkg::SEQ_DONE : spdr_pkg::SEQ_WRITE;
                  end
               end
               spdr_pkg::SEQ_LD_START: seq_now = spdr_pkg::SEQ_LD_END;
               spdr_pkg::SEQ_LD_END: begin
                  seq_now = all_done ? spdr_pkg::SEQ_DONE : spdr_pkg::SEQ_WRITE;
               end
               spdr_pkg::SEQ_DONE: begin
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                     d = readback_raw[i][spdr_pkg::WORD_W-1:2];
                     if (reverse_cfg) begin
                        d[spdr_pkg::DATA_W-1:0] = mirror_bits(d[spdr_pkg::DATA_W-1:0]);
                     end
                     readback_decoded[i] = d[spdr_pkg::DATA_W-1:0];
                     if (d[13:10] == channel_addr(i)) verified_flag[i] = 1'b1;
                  end
                  seq_now = spdr_pkg::SEQ_IDLE;
               end
               default: begin
                  // snapshot the frames and restart the counts
                  for (int i = 0; i < NUM_CHANNELS; i++) begin
                     dv = reverse_cfg ? mirror_bits(wanted_value[i]) : wanted_value[i];
                     tx_frame[i] = {2'b00, channel_addr(i), dv};
                  end
                  sent_total = '0;
                  recv_total = '0;
                  seq_now = spdr_pkg::SEQ_WRITE;
               end
            endcase
         end
      endcase
      r.ld_active = (seq_now == spdr_pkg::SEQ_LD_END);
      r.busy = (seq_now != spdr_pkg::SEQ_IDLE);
      return r;
   endfunction

   function automatic logic [spdr_pkg::ADDR_W-1:0] pick_address();
      if ($urandom_range(0, 99) < 85) begin
         return channel_addr(int'($urandom_range(0, NUM_CHANNELS-1)));
      end
      return spdr_pkg::ADDR_W'($urandom_range(0, 15));
   endfunction

   task automatic push_request(logic [spdr_pkg::MODE_W-1:0] mode,
                               logic [spdr_pkg::ADDR_W-1:0] addr,
                               logic [spdr_pkg::DATA_W-1:0] value,
                               logic [spdr_pkg::WORD_W-1:0] rx);
      dac_req_type w;
      w.mode = mode;
      w.addr = addr;
      w.value = value;
      w.rx = rx;
      queued_requests.push_back(w);
   endtask

   // Pick the word that moves the refresh forward, with some noise mixed in
   task automatic plan_next_request(output int counted);
      dac_req_type w;
      int          roll;
      w.mode = spdr_pkg::MODE_TICK;
      w.addr = spdr_pkg::ADDR_W'($urandom_range(0, 15));
      w.value = spdr_pkg::DATA_W'($urandom_range(0, 1023));
      w.rx = spdr_pkg::WORD_W'($urandom_range(0, 65535));
      counted = 1;
      roll = int'($urandom_range(0, 99));
      if (roll < 4) begin
         w.mode = spdr_pkg::MODE_W'($urandom_range(0, 3));
         counted = 0;
      end else if (roll < 8) begin
         w.mode = spdr_pkg::MODE_SET;
         w.addr = pick_address();
      end else if (roll < 14) begin
         w.mode = spdr_pkg::MODE_GET;
         w.addr = pick_address();
      end else if (seq_now == spdr_pkg::SEQ_WAIT && recv_total < sent_total) begin
         w.mode = spdr_pkg::MODE_RX;
         // second word of a pair: mostly echo the channel address so it verifies
         if (recv_total[0] && $urandom_range(0, 99) < 85)
            w.rx[15:12] = channel_addr(int'(recv_total >> 1));
      end
      queued_requests.push_back(w);
   endtask

   task automatic wait_requests_taken();
      do @(negedge clock); while (queued_requests.size() != 0 || req_ch.valid);
   endtask

   task automatic drain_block();
      wait_requests_taken();
      while (awaited_responses.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [spdr_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         spdr_pkg::REG_MAP:     map_cfg = data[spdr_pkg::MAP_W-1:0];
         spdr_pkg::REG_REVERSE: reverse_cfg = data[0];
         spdr_pkg::REG_LD_MODE: ld_first_cfg = data[0];
         default:               ;
      endcase
   endtask

   task automatic check_field(string name, logic [FIELD_W-1:0] want,
                              logic [FIELD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : request_driver
      dac_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            awaited_responses.push_back(predict_refresh_response({req_ch.mode,
               req_ch.channel_address, req_ch.channel_value, req_ch.rx_word}));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = queued_requests.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.mode <= nxt.mode;
               req_ch.channel_address <= nxt.addr;
               req_ch.channel_value <= nxt.value;
               req_ch.rx_word <= nxt.rx;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : response_monitor
      dac_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_responses.size() == 0) begin
            $error("response word with no request pending");
            mismatches++;
         end else begin
            want = awaited_responses.pop_front();
            check_field("tx_valid", FIELD_W'(want.tx_valid), FIELD_W'(rsp_ch.tx_valid));
            check_field("tx_word", want.tx_word, rsp_ch.tx_word);
            check_field("ld_active", FIELD_W'(want.ld_active), FIELD_W'(rsp_ch.ld_active));
            check_field("lookup_found", FIELD_W'(want.lookup_found),
                        FIELD_W'(rsp_ch.lookup_found));
            check_field("readback_valid", FIELD_W'(want.readback_valid),
                        FIELD_W'(rsp_ch.readback_valid));
            check_field("readback_value", FIELD_W'(want.readback_value),
                        FIELD_W'(rsp_ch.readback_value));
            check_field("busy_res", FIELD_W'(want.busy), FIELD_W'(rsp_ch.busy_res));
         end
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int                         count;
      int                         counted;
      logic [spdr_pkg::MAP_W-1:0] map_word;
      logic                       rev_bit;
      logic                       ld_bit;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = spdr_pkg::MODE_SET;
      req_ch.channel_address = '0;
      req_ch.channel_value = '0;
      req_ch.rx_word = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      mismatches = 0;
      stall_cycles = 0;

      map_cfg = spdr_pkg::MAP_RESET;
      reverse_cfg = 1'b0;
      ld_first_cfg = 1'b0;
      seq_now = spdr_pkg::SEQ_IDLE;
      sent_total = '0;
      recv_total = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         wanted_value[i] = '0;
         verified_flag[i] = 1'b0;
         readback_raw[i] = '0;
         readback_decoded[i] = '0;
         tx_frame[i] = '0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0) begin
            drain_block();
            map_word = spdr_pkg::MAP_W'({$urandom, $urandom});
            case (phase)
               1: begin rev_bit = 1'b1; ld_bit = 1'b1; end
               2: begin map_word = '1; rev_bit = 1'b0; ld_bit = 1'b1; end
               3: begin map_word = '0; rev_bit = 1'b1; ld_bit = 1'b0; end
               default: begin rev_bit = 1'b0; ld_bit = 1'b0; end
            endcase
            csr_write(spdr_pkg::REG_MAP, spdr_pkg::CSR_DATA_W'(map_word));
            csr_write(spdr_pkg::REG_REVERSE, spdr_pkg::CSR_DATA_W'(rev_bit));
            csr_write(spdr_pkg::REG_LD_MODE, spdr_pkg::CSR_DATA_W'(ld_bit));
         end
         @(negedge clock);
         send_idle_pct = (phase < 2) ? 27 : (phase < 4) ? 57 : 0;
         recv_idle_pct = (phase < 2) ? 57 : (phase < 4) ? 27 : 0;

         if (phase == 0) begin
            // known and unknown addresses, value extremes
            push_request(spdr_pkg::MODE_SET, 4'd1, 10'h3FF, 16'h0000);
            push_request(spdr_pkg::MODE_SET, 4'd10, 10'h000, 16'hFFFF);
            push_request(spdr_pkg::MODE_SET, 4'd5, 10'h155, 16'h0000);
            push_request(spdr_pkg::MODE_SET, 4'd0, 10'h3FF, 16'h0000);
            push_request(spdr_pkg::MODE_SET, 4'd15, 10'h2AA, 16'h0000);
            push_request(spdr_pkg::MODE_GET, 4'd1, 10'h3FF, 16'h0000);
            push_request(spdr_pkg::MODE_GET, 4'd0, 10'h000, 16'h0000);
            // received word while idle is dropped
            push_request(spdr_pkg::MODE_RX, 4'd0, 10'h000, 16'hFFFF);
            push_request(spdr_pkg::MODE_TICK, 4'd0, 10'h000, 16'h0000);
            push_request(spdr_pkg::MODE_TICK, 4'd15, 10'h3FF, 16'hFFFF);
            push_request(spdr_pkg::MODE_RX, 4'd0, 10'h000, 16'h0000);
            // nothing pending: dropped
            push_request(spdr_pkg::MODE_RX, 4'd0, 10'h000, 16'hFFFF);
            push_request(spdr_pkg::MODE_TICK, 4'd0, 10'h000, 16'h0000);
            push_request(spdr_pkg::MODE_TICK, 4'd0, 10'h000, 16'h0000);
            push_request(spdr_pkg::MODE_TICK, 4'd0, 10'h000, 16'h0000);
            push_request(spdr_pkg::MODE_TICK, 4'd0, 10'h000, 16'h0000);
            push_request(spdr_pkg::MODE_RX, 4'd0, 10'h000, 16'h1FFF);
            push_request(spdr_pkg::MODE_GET, 4'd15, 10'h3FF, 16'hFFFF);
         end

         count = 0;
         wait_requests_taken();
         while (count < PHASE_ITEMS || seq_now != spdr_pkg::SEQ_IDLE) begin
            plan_next_request(counted);
            count += counted;
            wait_requests_taken();
         end
      end

      drain_block();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
